// File: src/tswp_pkg.sv
// Shared constants, codes and controller/datapath interface types for the tour swap block.
package tswp_pkg;

  localparam int unsigned MAX_CITIES = 64;
  localparam int unsigned CITY_W     = 6;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned STAT_W     = 2;

  localparam logic [LEN_W-1:0] LEN_MIN   = 7'd3;
  localparam logic [LEN_W-1:0] LEN_MAX   = 7'd64;
  localparam logic [LEN_W-1:0] LEN_RESET = 7'd8;

  localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
  localparam logic [OP_W-1:0] OP_SWAP   = 3'd1;
  localparam logic [OP_W-1:0] OP_SUCC   = 3'd2;
  localparam logic [OP_W-1:0] OP_ENUM   = 3'd3;
  localparam logic [OP_W-1:0] OP_ACCEPT = 3'd4;

  localparam logic [STAT_W-1:0] ST_KEY       = 2'd0;
  localparam logic [STAT_W-1:0] ST_LOADED    = 2'd1;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD       = 2'd3;

  typedef enum logic [1:0] {
    SWEEP_PROPOSE,
    SWEEP_SEARCH,
    SWEEP_COPY
  } sweep_mode_e;

  typedef enum logic [2:0] {
    RA_POS_A,
    RA_POS_B,
    RA_IDX,
    RA_ZM1,
    RA_ZP1,
    RA_EMIT
  } rd_addr_e;

  typedef struct packed {
    logic              latch;
    logic              set_succ;
    logic              use_enum;
    logic              enum_clr;
    logic              load_wr;
    logic              single;
    logic [STAT_W-1:0] single_status;
    rd_addr_e          rd_addr;
    logic              bank_prop;
    logic              sweep_clr;
    logic              sweep_step;
    sweep_mode_e       sweep_mode;
    logic              cap_va;
    logic              cap_left;
    logic              set_dir;
    logic              emit_clr;
    logic              emit_step;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            req_bad;
    logic            enum_exh;
    logic            sweep_len_end;
    logic            sweep_all_end;
    logic            emit_end;
  } sts_t;

endpackage

// File: src/tswp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tswp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/tswp_dp.sv
// Datapath: tour memories, swap sweep, zero search, neighbor compare and key emission.
module tswp_dp import tswp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LEN_W-1:0]  cfg_wdata_i,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [POS_W-1:0]  pos_a_i,
  input  logic [POS_W-1:0]  pos_b_i,
  input  logic [CITY_W-1:0] city_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic              valid_o,
  output logic [STAT_W-1:0] status_o,
  output logic [CITY_W-1:0] key_city_o,
  output logic              last_o
);

  // Control registers.
  logic [LEN_W-1:0] tour_len_q, tour_len_d;
  logic [LEN_W-1:0] enum_q, enum_d;
  logic             out_valid_q, out_valid_d;
  logic             em_v_q;

  // Payload registers.
  logic [OP_W-1:0]   op_q;
  logic [POS_W-1:0]  a_q, b_q;
  logic [CITY_W-1:0] city_q;
  logic [LEN_W-1:0]  n_q;
  logic [CITY_W-1:0] va_q, vb_q, left_q;
  logic [LEN_W-1:0]  idx_q;
  logic              found_q;
  logic [POS_W-1:0]  z_q;
  logic              dir_down_q;
  logic [POS_W-1:0]  pos_q;
  logic [POS_W-1:0]  k_q;
  logic              em_last_q;
  logic              rsel_q;
  logic [STAT_W-1:0] out_status_q;
  logic [CITY_W-1:0] out_city_q;
  logic              out_last_q;

  logic [LEN_W-1:0]  eff_len;
  logic [POS_W-1:0]  src_pos, succ_pos;
  logic [LEN_W-1:0]  src_inc;
  logic [LEN_W-1:0]  nm1_w, nm2_w, idx_m1, z_inc, pos_inc;
  logic [POS_W-1:0]  nm1, nm2, pidx, zm1, zp1, pos_next;
  logic              proc, in_range, zero_hit, a_ge, b_ge, left_lt, req_bad;
  logic [CITY_W-1:0] rdata, c_rdata, p_rdata, swapped, val;
  logic [POS_W-1:0]  raddr;
  logic              c_we, p_we;
  logic [POS_W-1:0]  c_waddr;
  logic [CITY_W-1:0] c_wdata;

  // Register value saturated into the legal tour length range.
  always_comb begin
    if (tour_len_q < LEN_MIN) begin
      eff_len = LEN_MIN;
    end else if (tour_len_q > LEN_MAX) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = tour_len_q;
    end
  end

  assign nm1_w = n_q - 7'd1;
  assign nm2_w = n_q - 7'd2;
  assign nm1   = nm1_w[POS_W-1:0];
  assign nm2   = nm2_w[POS_W-1:0];

  assign src_pos  = cmd_i.use_enum ? enum_q[POS_W-1:0] : a_q;
  assign src_inc  = {1'b0, src_pos} + 7'd1;
  assign succ_pos = (src_inc == n_q) ? '0 : src_inc[POS_W-1:0];

  assign a_ge = {1'b0, a_q} >= n_q;
  assign b_ge = {1'b0, b_q} >= n_q;

  always_comb begin
    unique case (op_q)
      OP_LOAD, OP_SUCC: req_bad = a_ge;
      OP_SWAP:          req_bad = a_ge | b_ge | (a_q == b_q);
      default:          req_bad = 1'b0;
    endcase
  end

  assign sts_o.op            = op_q;
  assign sts_o.req_bad       = req_bad;
  assign sts_o.enum_exh      = enum_q >= n_q;
  assign sts_o.sweep_len_end = idx_q == n_q;
  assign sts_o.sweep_all_end = idx_q == LEN_MAX;
  assign sts_o.emit_end      = k_q == nm2;

  // Sweep: the read for index idx_q is issued now, the data of idx_q-1 is handled now.
  assign rdata    = rsel_q ? p_rdata : c_rdata;
  assign idx_m1   = idx_q - 7'd1;
  assign pidx     = idx_m1[POS_W-1:0];
  assign proc     = cmd_i.sweep_step && (idx_q != '0);
  assign in_range = {1'b0, pidx} < n_q;

  always_comb begin
    if (pidx == a_q) begin
      swapped = vb_q;
    end else if (pidx == b_q) begin
      swapped = va_q;
    end else begin
      swapped = rdata;
    end
  end

  assign val      = (cmd_i.sweep_mode == SWEEP_PROPOSE) ? swapped : rdata;
  assign zero_hit = proc && (cmd_i.sweep_mode != SWEEP_COPY) && in_range &&
                    (val == '0) && !found_q;

  // Neighbors of the key start, and the walk around the tour.
  assign z_inc   = {1'b0, z_q} + 7'd1;
  assign zm1     = (z_q == '0) ? nm1 : z_q - 6'd1;
  assign zp1     = (z_inc == n_q) ? '0 : z_inc[POS_W-1:0];
  assign pos_inc = {1'b0, pos_q} + 7'd1;
  assign left_lt = left_q < rdata;

  always_comb begin
    if (dir_down_q) begin
      pos_next = (pos_q == '0) ? nm1 : pos_q - 6'd1;
    end else begin
      pos_next = (pos_inc == n_q) ? '0 : pos_inc[POS_W-1:0];
    end
  end

  always_comb begin
    unique case (cmd_i.rd_addr)
      RA_POS_A: raddr = a_q;
      RA_POS_B: raddr = b_q;
      RA_IDX:   raddr = idx_q[POS_W-1:0];
      RA_ZM1:   raddr = zm1;
      RA_ZP1:   raddr = zp1;
      RA_EMIT:  raddr = pos_q;
      default:  raddr = '0;
    endcase
  end

  assign c_we    = cmd_i.load_wr | (proc && (cmd_i.sweep_mode == SWEEP_COPY));
  assign c_waddr = cmd_i.load_wr ? a_q : pidx;
  assign c_wdata = cmd_i.load_wr ? city_q : rdata;
  assign p_we    = proc && (cmd_i.sweep_mode == SWEEP_PROPOSE);

  tswp_ram #(
    .WIDTH(CITY_W),
    .DEPTH(MAX_CITIES)
  ) u_cur_ram (
    .clk_i  (clk_i),
    .we_i   (c_we),
    .waddr_i(c_waddr),
    .wdata_i(c_wdata),
    .raddr_i(raddr),
    .rdata_o(c_rdata)
  );

  tswp_ram #(
    .WIDTH(CITY_W),
    .DEPTH(MAX_CITIES)
  ) u_prop_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(pidx),
    .wdata_i(swapped),
    .raddr_i(raddr),
    .rdata_o(p_rdata)
  );

  always_comb begin
    tour_len_d = tour_len_q;
    if (cfg_we_i) begin
      tour_len_d = cfg_wdata_i;
    end
    enum_d = enum_q;
    if (cmd_i.enum_clr) begin
      enum_d = '0;
    end else if (cmd_i.set_succ && cmd_i.use_enum) begin
      enum_d = enum_q + 7'd1;
    end
    out_valid_d = cmd_i.single | em_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tour_len_q  <= LEN_RESET;
      enum_q      <= '0;
      out_valid_q <= 1'b0;
      em_v_q      <= 1'b0;
    end else begin
      tour_len_q  <= tour_len_d;
      enum_q      <= enum_d;
      out_valid_q <= out_valid_d;
      em_v_q      <= cmd_i.emit_step;
    end
  end

  always_ff @(posedge clk_i) begin
    rsel_q <= cmd_i.bank_prop;
    if (cmd_i.latch) begin
      op_q   <= operation_i;
      a_q    <= pos_a_i;
      b_q    <= pos_b_i;
      city_q <= city_i;
      n_q    <= eff_len;
    end
    if (cmd_i.set_succ) begin
      a_q <= src_pos;
      b_q <= succ_pos;
    end
    if (cmd_i.cap_va) begin
      va_q <= rdata;
    end
    if (cmd_i.sweep_clr) begin
      idx_q   <= '0;
      found_q <= 1'b0;
      z_q     <= '0;
    end else if (cmd_i.sweep_step) begin
      idx_q <= idx_q + 7'd1;
      // The second swap value arrives in the first sweep cycle.
      if (idx_q == '0) begin
        vb_q <= rdata;
      end
      if (zero_hit) begin
        found_q <= 1'b1;
        z_q     <= pidx;
      end
    end
    if (cmd_i.cap_left) begin
      left_q <= rdata;
    end
    if (cmd_i.set_dir) begin
      dir_down_q <= left_lt;
      pos_q      <= left_lt ? zm1 : zp1;
    end else if (cmd_i.emit_step) begin
      pos_q <= pos_next;
    end
    if (cmd_i.emit_clr) begin
      k_q <= '0;
    end else if (cmd_i.emit_step) begin
      k_q <= k_q + 6'd1;
    end
    em_last_q <= sts_o.emit_end;
    if (em_v_q) begin
      out_status_q <= ST_KEY;
      out_city_q   <= rdata;
      out_last_q   <= em_last_q;
    end else if (cmd_i.single) begin
      out_status_q <= cmd_i.single_status;
      out_city_q   <= '0;
      out_last_q   <= 1'b1;
    end
  end

  assign valid_o    = out_valid_q;
  assign status_o   = out_status_q;
  assign key_city_o = out_city_q;
  assign last_o     = out_last_q;

endmodule

// File: src/tswp_ctrl.sv
// Controller state machine that sequences loads, proposals, accepts and key emission.
module tswp_ctrl import tswp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_RD_A     = 4'd2;
  localparam logic [3:0] S_RD_B     = 4'd3;
  localparam logic [3:0] S_SWEEP_P  = 4'd4;
  localparam logic [3:0] S_SWEEP_S  = 4'd5;
  localparam logic [3:0] S_SWEEP_C  = 4'd6;
  localparam logic [3:0] S_NB_L     = 4'd7;
  localparam logic [3:0] S_NB_R     = 4'd8;
  localparam logic [3:0] S_NB_CMP   = 4'd9;
  localparam logic [3:0] S_EMIT     = 4'd10;
  localparam logic [3:0] S_EMIT_END = 4'd11;

  logic [3:0] state_q, state_d;
  logic       key_bank;

  // An accept emits the key of the current tour, every other key comes from the proposal.
  assign key_bank = sts_i.op != OP_ACCEPT;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        unique case (sts_i.op)
          OP_LOAD: begin
            cmd_o.single = 1'b1;
            if (sts_i.req_bad) begin
              cmd_o.single_status = ST_BAD;
            end else begin
              cmd_o.load_wr       = 1'b1;
              cmd_o.single_status = ST_LOADED;
            end
          end
          OP_SWAP: begin
            if (sts_i.req_bad) begin
              cmd_o.single        = 1'b1;
              cmd_o.single_status = ST_BAD;
            end else begin
              state_d = S_RD_A;
            end
          end
          OP_SUCC: begin
            if (sts_i.req_bad) begin
              cmd_o.single        = 1'b1;
              cmd_o.single_status = ST_BAD;
            end else begin
              cmd_o.set_succ = 1'b1;
              state_d        = S_RD_A;
            end
          end
          OP_ENUM: begin
            if (sts_i.enum_exh) begin
              cmd_o.enum_clr      = 1'b1;
              cmd_o.single        = 1'b1;
              cmd_o.single_status = ST_EXHAUSTED;
            end else begin
              cmd_o.set_succ = 1'b1;
              cmd_o.use_enum = 1'b1;
              state_d        = S_RD_A;
            end
          end
          OP_ACCEPT: begin
            cmd_o.sweep_clr = 1'b1;
            state_d         = S_SWEEP_S;
          end
          default: begin
            cmd_o.single        = 1'b1;
            cmd_o.single_status = ST_BAD;
          end
        endcase
      end
      S_RD_A: begin
        cmd_o.rd_addr = RA_POS_A;
        state_d       = S_RD_B;
      end
      S_RD_B: begin
        cmd_o.rd_addr   = RA_POS_B;
        cmd_o.cap_va    = 1'b1;
        cmd_o.sweep_clr = 1'b1;
        state_d         = S_SWEEP_P;
      end
      S_SWEEP_P: begin
        cmd_o.rd_addr    = RA_IDX;
        cmd_o.sweep_step = 1'b1;
        cmd_o.sweep_mode = SWEEP_PROPOSE;
        if (sts_i.sweep_all_end) begin
          state_d = S_NB_L;
        end
      end
      S_SWEEP_S: begin
        cmd_o.rd_addr    = RA_IDX;
        cmd_o.sweep_step = 1'b1;
        cmd_o.sweep_mode = SWEEP_SEARCH;
        if (sts_i.sweep_len_end) begin
          state_d = S_NB_L;
        end
      end
      S_SWEEP_C: begin
        cmd_o.rd_addr    = RA_IDX;
        cmd_o.bank_prop  = 1'b1;
        cmd_o.sweep_step = 1'b1;
        cmd_o.sweep_mode = SWEEP_COPY;
        if (sts_i.sweep_all_end) begin
          state_d = S_IDLE;
        end
      end
      S_NB_L: begin
        cmd_o.rd_addr   = RA_ZM1;
        cmd_o.bank_prop = key_bank;
        state_d         = S_NB_R;
      end
      S_NB_R: begin
        cmd_o.rd_addr   = RA_ZP1;
        cmd_o.bank_prop = key_bank;
        cmd_o.cap_left  = 1'b1;
        state_d         = S_NB_CMP;
      end
      S_NB_CMP: begin
        cmd_o.set_dir  = 1'b1;
        cmd_o.emit_clr = 1'b1;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.rd_addr   = RA_EMIT;
        cmd_o.bank_prop = key_bank;
        cmd_o.emit_step = 1'b1;
        if (sts_i.emit_end) begin
          if (sts_i.op == OP_ACCEPT) begin
            // The proposal becomes current once the key of the current tour has been read out.
            cmd_o.sweep_clr = 1'b1;
            state_d         = S_SWEEP_C;
          end else begin
            state_d = S_EMIT_END;
          end
        end
      end
      S_EMIT_END: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = state_q != S_IDLE;

endmodule

// File: src/tour_swap_move_canonicalizer.sv
// Top level of the tour swap move canonicalizer: controller plus datapath.
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+-------------------------------------
//   request  | start, busy (taken: start&~busy) | operation_i, pos_a_i, pos_b_i, city_i
//   result   | valid_o, one-cycle beat        | status_o, key_city_o, last_o
//   config   | cfg_we_i                       | cfg_wdata_i (tour_length)
//
// A load, a bad request or an exhausted enumeration keeps busy high for one cycle.
// A proposal keeps busy high through a copy-and-swap sweep from the current tour memory
// into the proposal memory, a read and compare of the neighbors of city 0, then one key
// beat per cycle. An accept runs a zero search and key readout from the current tour,
// then a copy of the proposal back. Each tour memory has one read port.
// Reset clears the controller, the enumeration counter and tour_length (to 8); the
// tour memories are not cleared. Result beats cannot be stalled by the receiver.
module tour_swap_move_canonicalizer import tswp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [POS_W-1:0]  pos_a_i,
  input  logic [POS_W-1:0]  pos_b_i,
  input  logic [CITY_W-1:0] city_i,
  input  logic              cfg_we_i,
  input  logic [LEN_W-1:0]  cfg_wdata_i,
  output logic              valid_o,
  output logic [STAT_W-1:0] status_o,
  output logic [CITY_W-1:0] key_city_o,
  output logic              last_o
);

  cmd_t cmd;
  sts_t sts;

  tswp_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .sts_i (sts),
    .cmd_o (cmd),
    .busy  (busy)
  );

  tswp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .operation_i(operation_i),
    .pos_a_i    (pos_a_i),
    .pos_b_i    (pos_b_i),
    .city_i     (city_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .valid_o    (valid_o),
    .status_o   (status_o),
    .key_city_o (key_city_o),
    .last_o     (last_o)
  );

endmodule

// File: sim/tb_tour_swap_move_canonicalizer.sv
`timescale 1ns / 100ps
// Self-checking testbench for the tour swap move canonicalizer with a key-predicting scoreboard.
module tb_tour_swap_move_canonicalizer import tswp_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASE_ITEMS = 32;
  localparam int unsigned NUM_PHASES  = 12;
  localparam int unsigned TAIL_CYCLES = 2 * MAX_CITIES + 80;
  localparam int unsigned POS_TOP     = (1 << POS_W) - 1;
  localparam int unsigned CITY_TOP    = (1 << CITY_W) - 1;

  localparam logic [LEN_W-1:0] PHASE_LEN [NUM_PHASES] =
    '{7'd5, 7'd127, 7'd3, 7'd12, 7'd64, 7'd1, 7'd9, 7'd2, 7'd65, 7'd4, 7'd33, 7'd7};
  localparam int unsigned PHASE_IDLE [4] = '{0, 67, 0, 18};

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CITY_W-1:0] city;
    logic              last;
  } key_beat_t;

  class tour_key_scoreboard;
    logic [CITY_W-1:0] cur_tour  [MAX_CITIES];
    logic [CITY_W-1:0] prop_tour [MAX_CITIES];
    logic [LEN_W-1:0]  succ_cursor;
    logic [LEN_W-1:0]  length_reg;
    bit                proposal_made;
    int unsigned       failures;
    key_beat_t         beats_due [$];

    function new();
      succ_cursor   = '0;
      length_reg    = LEN_RESET;
      proposal_made = 1'b0;
      failures      = 0;
      foreach (cur_tour[i]) begin
        cur_tour[i]  = '0;
        prop_tour[i] = '0;
      end
    endfunction

    // The register is saturated into the supported range of tour lengths.
    function int unsigned tour_len();
      if (length_reg < LEN_MIN) return LEN_MIN;
      if (length_reg > LEN_MAX) return LEN_MAX;
      return length_reg;
    endfunction

    function void expect_single(logic [STAT_W-1:0] st);
      key_beat_t b;
      b.status = st;
      b.city   = '0;
      b.last   = 1'b1;
      beats_due.push_back(b);
    endfunction

    // Start at city 0 (or position 0 if it is missing) and walk toward the
    // smaller neighbor; a tie walks toward higher positions.
    function void expect_key(bit from_proposal, int unsigned n);
      logic [CITY_W-1:0] t [MAX_CITIES];
      int unsigned       z, dir_step, i;
      bit                found;
      key_beat_t         b;
      if (from_proposal) t = prop_tour;
      else t = cur_tour;
      z     = 0;
      found = 1'b0;
      for (i = 0; i < n; i++) begin
        if (!found && t[i] == '0) begin
          z     = i;
          found = 1'b1;
        end
      end
      dir_step = (t[(z + n - 1) % n] < t[(z + 1) % n]) ? n - 1 : 1;
      for (i = 0; i + 1 < n; i++) begin
        z        = (z + dir_step) % n;
        b.status = ST_KEY;
        b.city   = t[z];
        b.last   = (i + 2 == n);
        beats_due.push_back(b);
      end
    endfunction

    function void propose(int unsigned a, int unsigned b, int unsigned n);
      logic [CITY_W-1:0] tmp;
      prop_tour     = cur_tour;
      tmp           = prop_tour[a];
      prop_tour[a]  = prop_tour[b];
      prop_tour[b]  = tmp;
      proposal_made = 1'b1;
      expect_key(1'b1, n);
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] a,
                               logic [POS_W-1:0] b, logic [CITY_W-1:0] c);
      int unsigned n;
      n = tour_len();
      case (op)
        OP_LOAD: begin
          if (a >= n) expect_single(ST_BAD);
          else begin
            cur_tour[a] = c;
            expect_single(ST_LOADED);
          end
        end
        OP_SWAP: begin
          if (a >= n || b >= n || a == b) expect_single(ST_BAD);
          else propose(a, b, n);
        end
        OP_SUCC: begin
          if (a >= n) expect_single(ST_BAD);
          else propose(a, (a + 1) % n, n);
        end
        OP_ENUM: begin
          if (succ_cursor >= n) begin
            succ_cursor = '0;
            expect_single(ST_EXHAUSTED);
          end else begin
            propose(succ_cursor, (succ_cursor + 1) % n, n);
            succ_cursor = succ_cursor + 1'b1;
          end
        end
        OP_ACCEPT: begin
          expect_key(1'b0, n);
          cur_tour = prop_tour;
        end
        default: expect_single(ST_BAD);
      endcase
    endfunction

    function void check_beat(logic [STAT_W-1:0] st, logic [CITY_W-1:0] c, logic l);
      key_beat_t want;
      if (beats_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result beat: status %0d city %0d last %0d", st, c, l);
        return;
      end
      want = beats_due.pop_front();
      if (want.status !== st || want.city !== c || want.last !== l) begin
        failures++;
        if (failures <= 10)
          $display("result mismatch: expected status %0d city %0d last %0d, got %0d %0d %0d",
                   want.status, want.city, want.last, st, c, l);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   operation_i = '0;
  logic [POS_W-1:0]  pos_a_i = '0;
  logic [POS_W-1:0]  pos_b_i = '0;
  logic [CITY_W-1:0] city_i = '0;
  logic              cfg_we_i = 1'b0;
  logic [LEN_W-1:0]  cfg_wdata_i = '0;
  logic              valid_o;
  logic [STAT_W-1:0] status_o;
  logic [CITY_W-1:0] key_city_o;
  logic              last_o;

  tour_key_scoreboard sb;
  int unsigned        cycle_count = 0;

  tour_swap_move_canonicalizer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .operation_i (operation_i),
    .pos_a_i     (pos_a_i),
    .pos_b_i     (pos_b_i),
    .city_i      (city_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_o     (valid_o),
    .status_o    (status_o),
    .key_city_o  (key_city_o),
    .last_o      (last_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_tour_swap_move_canonicalizer: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) sb.check_beat(status_o, key_city_o, last_o);
  end

  // Start stays high after a beat is taken; the caller lowers it when idling.
  task automatic send_request(logic [OP_W-1:0] op, logic [POS_W-1:0] a,
                              logic [POS_W-1:0] b, logic [CITY_W-1:0] c);
    @(negedge clk_i);
    start       = 1'b1;
    operation_i = op;
    pos_a_i     = a;
    pos_b_i     = b;
    city_i      = c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(op, a, b, c);
  endtask

  task automatic pause_gap(int unsigned pct);
    if ($urandom_range(0, 99) < pct) begin
      @(negedge clk_i);
      start = 1'b0;
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 150)) @(negedge clk_i);
      else repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
  endtask

  // Accept keeps working on the copy-back after its last key beat, so wait for busy too.
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.beats_due.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_length(logic [LEN_W-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i      = 1'b0;
    sb.length_reg = v;
  endtask

  task automatic random_request(int unsigned pct);
    int unsigned       n, pick;
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  a, b;
    logic [CITY_W-1:0] c;
    n    = sb.tour_len();
    pick = $urandom_range(0, 99);
    op   = OP_ENUM;
    a    = POS_W'($urandom);
    b    = POS_W'($urandom);
    c    = CITY_W'($urandom);
    if (pick < 15) begin
      op = OP_LOAD;
      a  = POS_W'($urandom_range(0, n - 1));
      // Small cities make missing zeros, duplicates and neighbor ties likely.
      if ($urandom_range(0, 3) == 0) c = CITY_W'($urandom_range(0, 3));
    end else if (pick < 40) begin
      op = OP_SWAP;
      a  = POS_W'($urandom_range(0, n - 1));
      b  = POS_W'($urandom_range(0, n - 2));
      if (b >= a) b = b + 1'b1;
    end else if (pick < 55) begin
      op = OP_SUCC;
      a  = POS_W'($urandom_range(0, n - 1));
    end else if (pick < 75) begin
      op = OP_ENUM;
    end else if (pick < 87) begin
      op = sb.proposal_made ? OP_ACCEPT : OP_ENUM;
    end else begin
      case ($urandom_range(0, 3))
        0: op = OP_ACCEPT + OP_W'($urandom_range(1, 3));
        1: begin
          op = OP_SWAP;
          b  = a;
        end
        default: begin
          if (n < MAX_CITIES) begin
            case ($urandom_range(0, 2))
              0: op = OP_LOAD;
              1: op = OP_SUCC;
              default: begin
                op = OP_SWAP;
                b  = POS_W'($urandom_range(0, n - 1));
              end
            endcase
            a = POS_W'($urandom_range(n, POS_TOP));
            if (op == OP_SWAP && $urandom_range(0, 1) == 1) begin
              a = b;
              b = POS_W'($urandom_range(n, POS_TOP));
            end
          end else begin
            op = OP_SWAP;
            b  = a;
          end
        end
      endcase
    end
    send_request(op, a, b, c);
    pause_gap(pct);
  endtask

  initial begin
    logic [CITY_W-1:0] perm [MAX_CITIES];
    logic [CITY_W-1:0] tmp;
    int unsigned       j;
    sb = new();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset length is 8: position 8 is out of range, position 7 is not.
    send_request(OP_LOAD, 6'd8, 6'd0, CITY_W'(CITY_TOP));
    send_request(OP_LOAD, 6'd7, POS_W'(POS_TOP), 6'd0);

    // Fill every entry with a shuffled full tour so no unwritten entry is ever read.
    write_length(LEN_MAX);
    foreach (perm[i]) perm[i] = CITY_W'(i);
    for (int unsigned i = MAX_CITIES - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    foreach (perm[i]) send_request(OP_LOAD, POS_W'(i), POS_W'($urandom), perm[i]);

    send_request(OP_ENUM, 6'd0, 6'd0, 6'd0);
    send_request(OP_ENUM, 6'd0, 6'd0, 6'd0);
    send_request(OP_ENUM, 6'd0, 6'd0, 6'd0);
    send_request(OP_ACCEPT, 6'd0, 6'd0, 6'd0);
    send_request(OP_SUCC, POS_W'(POS_TOP), 6'd0, 6'd0);
    send_request(OP_SWAP, POS_W'(POS_TOP), 6'd0, 6'd0);
    send_request(OP_SWAP, 6'd20, 6'd20, 6'd0);
    for (int unsigned k = 1; k <= 3; k++)
      send_request(OP_ACCEPT + OP_W'(k), POS_W'(POS_TOP), POS_W'(POS_TOP), CITY_W'(CITY_TOP));

    // Lowering the length below the enumeration position exhausts it at once.
    write_length('0);
    send_request(OP_ENUM, 6'd0, 6'd0, 6'd0);
    send_request(OP_ENUM, 6'd0, 6'd0, 6'd0);
    send_request(OP_LOAD, 6'd3, 6'd0, 6'd5);
    send_request(OP_LOAD, POS_W'(POS_TOP), 6'd0, CITY_W'(CITY_TOP));
    send_request(OP_SUCC, 6'd3, 6'd0, 6'd0);
    send_request(OP_SWAP, 6'd0, 6'd5, 6'd0);

    // Both neighbors of city 0 equal, in the current tour and in the proposal.
    send_request(OP_LOAD, 6'd0, 6'd0, 6'd9);
    send_request(OP_LOAD, 6'd1, 6'd0, 6'd0);
    send_request(OP_LOAD, 6'd2, 6'd0, 6'd9);
    send_request(OP_SUCC, 6'd0, 6'd0, 6'd0);
    send_request(OP_ACCEPT, 6'd0, 6'd0, 6'd0);

    // No city 0 left in the tour, and the successor of the last position.
    send_request(OP_LOAD, 6'd0, 6'd0, CITY_W'(CITY_TOP));
    send_request(OP_LOAD, 6'd1, 6'd0, 6'd62);
    send_request(OP_SWAP, 6'd0, 6'd2, 6'd0);
    send_request(OP_SUCC, 6'd2, 6'd0, 6'd0);
    send_request(OP_ACCEPT, 6'd0, 6'd0, 6'd0);

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      write_length(PHASE_LEN[p]);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) drain();
        random_request(PHASE_IDLE[p % 4]);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.beats_due.size() == 0) begin
      $display("tb_tour_swap_move_canonicalizer: PASS");
    end else begin
      $display("tb_tour_swap_move_canonicalizer: FAIL");
    end
    $finish;
  end

endmodule
